/* rtl/core/assert_macros.svh */
// Assertion macros used by the top level of the SHA-256 byte stream hasher.
// No dependencies; define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

/* rtl/core/shabs_pkg.sv */
// Shared types, constants and functions of the SHA-256 byte stream hasher.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package shabs_pkg;

  typedef logic [31:0] word_t;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0]  PAD_MARK   = 8'h80;
  localparam logic [63:0] BLOCK_BITS = 64'd512;

  // Control from the sequencer to the message schedule window.
  typedef struct packed {
    logic       shift_byte;
    logic       shift_word;
    logic [7:0] byte_val;
  } sched_ctrl_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       load;
    logic       step;
    logic       fold;
    logic       out_shift;
    logic [2:0] out_idx;
  } rnd_ctrl_t;

  function automatic word_t ror32(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/shabs_sched.sv */
// Message block buffer and schedule window of the SHA-256 hasher.
// Depends on shabs_pkg for the control struct and the sigma functions.
`timescale 1ns / 1ps
`default_nettype none

module shabs_sched
  import shabs_pkg::*;
(
  input  wire         clk_i,
  input  sched_ctrl_t ctrl_i,
  output word_t       w_o
);

  // The 64-byte block as one shift line; the first byte sits at the top.
  // During compression the same line holds W[t] .. W[t+15], W[t] at the top.
  logic [511:0] line_q, line_d;
  word_t        w_new;

  assign w_new = line_q[511:480] + small_sig0(line_q[479:448])
               + line_q[223:192] + small_sig1(line_q[63:32]);

  always_comb begin
    line_d = line_q;
    if (ctrl_i.shift_byte) begin
      line_d = {line_q[503:0], ctrl_i.byte_val};
    end else if (ctrl_i.shift_word) begin
      line_d = {line_q[479:0], w_new};
    end
  end

  // Payload only; the reset leaves the buffer as it is.
  always_ff @(posedge clk_i) begin
    line_q <= line_d;
  end

  assign w_o = line_q[511:480];

endmodule

`default_nettype wire

/* rtl/core/shabs_round.sv */
// Round unit of the SHA-256 hasher: working variables, hash words, one round per step.
// Depends on shabs_pkg for the control struct, initial hash values and sigma functions.
`timescale 1ns / 1ps
`default_nettype none

module shabs_round
  import shabs_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  rnd_ctrl_t ctrl_i,
  input  word_t     k_i,
  input  word_t     w_i,
  output word_t     digest_o
);

  word_t hash_q [8];
  word_t v_q    [8];
  word_t v_d    [8];
  word_t t1, t2, ch, maj;

  always_comb begin
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + big_sig1(v_q[4]) + ch + k_i + w_i;
    t2  = big_sig0(v_q[0]) + maj;
    v_d[0] = t1 + t2;
    v_d[1] = v_q[0];
    v_d[2] = v_q[1];
    v_d[3] = v_q[2];
    v_d[4] = v_q[3] + t1;
    v_d[5] = v_q[4];
    v_d[6] = v_q[5];
    v_d[7] = v_q[6];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      v_q <= hash_q;
    end else if (ctrl_i.step) begin
      v_q <= v_d;
    end
  end

  // While the digest goes out the words rotate toward index 0 and the
  // initial values refill from the top, so the chain is reset when done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HASH_IV;
    end else if (ctrl_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= hash_q[i] + v_q[i];
      end
    end else if (ctrl_i.out_shift) begin
      for (int i = 0; i < 7; i++) begin
        hash_q[i] <= hash_q[i+1];
      end
      hash_q[7] <= HASH_IV[ctrl_i.out_idx];
    end
  end

  assign digest_o = hash_q[0];

endmodule

`default_nettype wire

/* rtl/core/sha256_byte_stream_hasher_unit.sv */
// SHA-256 byte stream hasher, top level: handshake, sequencer and padding.
// Depends on shabs_pkg, shabs_sched, shabs_round and assert_macros.svh.
//
// Usage: message bytes enter on the s_axis channel, one transaction each.
// tdata[7:0] is the byte, tuser flags that the byte is present, and tlast
// ends the message (a byte in the same transaction belongs to the message).
// The digest leaves on m_axis as eight transactions: tdata is the 32-bit
// word, most significant word first, tuser the word index, tlast the eighth.
// A byte that does not complete a 64-byte block is absorbed in its accept
// cycle, so such bytes can follow back to back, one per cycle.
// A byte that completes a block also loads the round unit in that cycle and
// keeps s_axis_tready low through the 64 rounds, one per cycle, and a fold.
// At the end of a message the rest of the block is filled with padding, one
// byte per cycle (the last padding byte loading the round unit), and then
// compressed; when the 0x80 marker leaves no room for the length, a second
// block of padding follows and is compressed as well.
// s_axis_tready is low during all of that and while the digest goes out.
// If the receiver stalls, the current digest word is held until taken.
// After the eighth word the hasher is back at the initial hash values.
// Reset (rst_ni low) clears the length count and loads the initial hash.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sha256_byte_stream_hasher_unit
  import shabs_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire         s_axis_tuser,   // [0] byte_present
  input  wire         s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] len_q, len_d;
  logic        pad_q, pad_d;       // message end seen, padding owed
  logic        mark_q, mark_d;     // 0x80 marker already in the buffer
  logic        len_ok_q, len_ok_d; // length field goes into this block

  sched_ctrl_t sched_ctrl;
  rnd_ctrl_t   rnd_ctrl;
  word_t       w_cur;
  word_t       digest;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rnd_d      = rnd_q;
    out_idx_d  = out_idx_q;
    bits_d     = bits_q;
    len_d      = len_q;
    pad_d      = pad_q;
    mark_d     = mark_q;
    len_ok_d   = len_ok_q;
    sched_ctrl = '0;
    rnd_ctrl   = '0;
    rnd_ctrl.out_idx = out_idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            sched_ctrl.shift_byte = 1'b1;
            sched_ctrl.byte_val   = s_axis_tdata;
            cnt_d = cnt_q + 6'd1;
          end
          if (s_axis_tlast) begin
            pad_d = 1'b1;
          end
          if (s_axis_tuser && (cnt_q == 6'd63)) begin
            state_d       = ST_ROUND;
            rnd_ctrl.load = 1'b1;
            rnd_d         = '0;
          end else if (s_axis_tlast) begin
            state_d = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        sched_ctrl.shift_byte = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (!mark_q) begin
          sched_ctrl.byte_val = PAD_MARK;
          mark_d   = 1'b1;
          len_d    = bits_q + 64'({cnt_q, 3'b000});
          len_ok_d = (cnt_q < 6'd56);
        end else if (len_ok_q && (cnt_q >= 6'd56)) begin
          // Length bytes go out big-endian: position 56 takes bits 63:56.
          sched_ctrl.byte_val = len_q[{~cnt_q[2:0], 3'b000} +: 8];
        end else begin
          sched_ctrl.byte_val = 8'h00;
        end
        if (cnt_q == 6'd63) begin
          state_d       = ST_ROUND;
          rnd_ctrl.load = 1'b1;
          rnd_d         = '0;
        end
      end

      ST_ROUND: begin
        rnd_ctrl.step         = 1'b1;
        sched_ctrl.shift_word = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_FINAL;
        end
      end

      ST_FINAL: begin
        rnd_ctrl.fold = 1'b1;
        if (!mark_q) begin
          bits_d = bits_q + BLOCK_BITS;
        end
        if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (!mark_q) begin
          state_d = ST_PAD;
        end else if (len_ok_q) begin
          state_d   = ST_OUT;
          out_idx_d = '0;
        end else begin
          // The marker did not leave room for the length: one more block.
          len_ok_d = 1'b1;
          state_d  = ST_PAD;
        end
      end

      ST_OUT: begin
        if (m_axis_tready) begin
          rnd_ctrl.out_shift = 1'b1;
          out_idx_d = out_idx_q + 3'd1;
          if (out_idx_q == 3'd7) begin
            state_d  = ST_IDLE;
            cnt_d    = '0;
            bits_d   = '0;
            pad_d    = 1'b0;
            mark_d   = 1'b0;
            len_ok_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rnd_q     <= '0;
      out_idx_q <= '0;
      bits_q    <= '0;
      pad_q     <= 1'b0;
      mark_q    <= 1'b0;
      len_ok_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rnd_q     <= rnd_d;
      out_idx_q <= out_idx_d;
      bits_q    <= bits_d;
      pad_q     <= pad_d;
      mark_q    <= mark_d;
      len_ok_q  <= len_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

  shabs_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (w_cur)
  );

  shabs_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (rnd_ctrl),
    .k_i      (ROUND_K[rnd_q]),
    .w_i      (w_cur),
    .digest_o (digest)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = digest;
  assign m_axis_tuser  = out_idx_q;
  assign m_axis_tlast  = (out_idx_q == 3'd7);

  `ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, s_axis_tready && m_axis_tvalid)
  `ASSERT_PROP(a_rounds_end, clk_i, rst_ni, (state_q == ST_ROUND) && (rnd_q == 6'd63) |=> (state_q == ST_FINAL))
  `ASSERT_PROP(a_back_idle, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && (cnt_q == 6'd0) && !mark_q)
  `ASSERT_PROP(a_digest_has_len, clk_i, rst_ni, m_axis_tvalid |-> mark_q && len_ok_q && pad_q)

endmodule

`default_nettype wire

/* dv/sha256_digest_checker.sv */
// Digest checker for the SHA-256 byte stream hasher: follows the byte stream,
// recomputes the hash of every message and compares each digest word.
// Self-contained; the testbench top connects it beside the hasher instance.
`timescale 1ns / 1ps

module sha256_digest_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_tvalid_i,
  input  wire        in_tready_i,
  input  wire  [7:0] in_tdata_i,    // [7:0] data_byte
  input  wire        in_tuser_i,    // [0] byte_present
  input  wire        in_tlast_i,    // end_of_message
  input  wire        out_tvalid_i,
  input  wire        out_tready_i,
  input  wire [31:0] out_tdata_i,   // [31:0] digest_word
  input  wire  [2:0] out_tuser_i,   // [2:0] word_index
  input  wire        out_tlast_i,   // last_word
  output int         errors_o,
  output int         pending_o
);

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic [31:0]  chain_q [8];
  logic [7:0]   msg_block [64];
  int unsigned  block_fill;
  logic [63:0]  length_bits;
  digest_word_t digest_fifo [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] digest check: %s", $time, msg);
    errors_o++;
  endtask

  task automatic restart_message();
    chain_q     = START_HASH;
    block_fill  = 0;
    length_bits = '0;
    foreach (msg_block[i]) msg_block[i] = '0;
  endtask

  // One full compression of msg_block into the chaining value.
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    v = chain_q;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] = chain_q[i] + v[i];
  endtask

  task automatic absorb_item(input logic [7:0] data, input logic present, input logic eom);
    int unsigned  n;
    logic [63:0]  total;
    digest_word_t entry;
    if (present) begin
      msg_block[block_fill] = data;
      block_fill++;
      if (block_fill == 64) begin
        compress_block();
        length_bits = length_bits + 64'd512;
        block_fill  = 0;
      end
    end
    if (eom) begin
      n     = block_fill;
      total = length_bits + 64'(block_fill * 8);
      msg_block[n] = PAD_BYTE;
      n++;
      // No room left for the length field: close this block and pad a new one.
      if (n > 56) begin
        while (n < 64) begin
          msg_block[n] = '0;
          n++;
        end
        compress_block();
        n = 0;
      end
      while (n < 56) begin
        msg_block[n] = '0;
        n++;
      end
      for (int i = 0; i < 8; i++) msg_block[56+i] = total[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        entry = '{word: chain_q[i], index: 3'(i), last: (i == 7)};
        digest_fifo = {digest_fifo, entry};
      end
      restart_message();
    end
  endtask

  task automatic check_word();
    digest_word_t want;
    if (digest_fifo.size() == 0) begin
      report_error($sformatf("unexpected word %h index %0d last %0b",
                             out_tdata_i, out_tuser_i, out_tlast_i));
      return;
    end
    want = digest_fifo.pop_front();
    if (out_tdata_i !== want.word)
      report_error($sformatf("word %0d: got %h, want %h", want.index, out_tdata_i, want.word));
    if (out_tuser_i !== want.index)
      report_error($sformatf("index: got %0d, want %0d", out_tuser_i, want.index));
    if (out_tlast_i !== want.last)
      report_error($sformatf("last flag on word %0d: got %0b, want %0b",
                             want.index, out_tlast_i, want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_message();
      digest_fifo.delete();
      pending_o <= 0;
    end else begin
      if (in_tvalid_i && in_tready_i) absorb_item(in_tdata_i, in_tuser_i, in_tlast_i);
      if (out_tvalid_i && out_tready_i) check_word();
      pending_o <= digest_fifo.size();
    end
  end

endmodule

/* dv/sha256_byte_stream_hasher_unit_tb.sv */
// Testbench top for the SHA-256 byte stream hasher: clock, reset, message
// stimulus, output back-pressure and the verdict.
// Depends on sha256_byte_stream_hasher_unit and sha256_digest_checker.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_unit_tb;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int TAIL_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int SRC_IDLE_PCT [3]   = '{6, 63, 0};
  localparam int SINK_STALL_PCT [3] = '{63, 6, 0};
  // Lengths around the point where the length field no longer fits.
  localparam int BOUNDARY_LEN [7]   = '{55, 56, 57, 63, 64, 65, 119};

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic [7:0]  s_axis_tdata   = 8'h00;
  logic        s_axis_tuser   = 1'b0;
  logic        s_axis_tlast   = 1'b0;
  logic        m_axis_tready  = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [31:0] m_axis_tdata;
  wire  [2:0]  m_axis_tuser;
  wire         m_axis_tlast;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int quiet_cycles   = 0;
  int errors;
  int pending;
  int items_sent    = 0;
  int noise_sent    = 0;
  int messages_sent = 0;
  int bytes_sent    = 0;
  int bare_ends     = 0;

  always #6 clk_i = ~clk_i;

  sha256_byte_stream_hasher_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sha256_digest_checker i_digest_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tvalid_i  (s_axis_tvalid),
    .in_tready_i  (s_axis_tready),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .in_tlast_i   (s_axis_tlast),
    .out_tvalid_i (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_i  (m_axis_tdata),
    .out_tuser_i  (m_axis_tuser),
    .out_tlast_i  (m_axis_tlast),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Ends the run when neither channel completes a transaction for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
      $display("Watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= present;
    s_axis_tlast  <= eom;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (present || eom) items_sent++;
    else noise_sent++;
    if (present) bytes_sent++;
    if (eom) messages_sent++;
    if (eom && !present) bare_ends++;
  endtask

  // Random bytes with an occasional empty transaction mixed in; the end flag
  // rides on the last byte or comes in a transaction of its own.
  task automatic send_message(input int len, input logic fused_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, fused_end && (i == len - 1));
    end
    if (!fused_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 62) return $urandom_range(12);
    if (roll < 77) return BOUNDARY_LEN[$urandom_range(6)];
    if (roll < 90) return $urandom_range(70, 45);
    return $urandom_range(140, 100);
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct   = SRC_IDLE_PCT[ph];
      sink_stall_pct = SINK_STALL_PCT[ph];
      if (ph == 0) begin
        // Empty message.
        send_item(8'hA5, 1'b0, 1'b1);
        // "abc" with the end flag on its last byte.
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // A single all-ones byte that also ends the message.
        send_item(8'hFF, 1'b1, 1'b1);
        // A zero byte, then an end with no byte.
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        // Empty transactions between bytes must leave the message unchanged.
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
        // Back-to-back empty messages: the hash must restart from scratch.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
      end
      while (items_sent < (ph + 1) * ITEMS_PER_PHASE)
        send_message(pick_length(), 1'($urandom_range(1)));
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Hashed %0d messages: %0d bytes, %0d ends without a byte, %0d empty transactions.",
             messages_sent, bytes_sent, bare_ends, noise_sent);
    $display("Pacing: slow receiver, then slow sender, then both sides at full rate.");
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/shabs_pkg.sv
rtl/core/shabs_sched.sv
rtl/core/shabs_round.sv
rtl/core/sha256_byte_stream_hasher_unit.sv
dv/sha256_digest_checker.sv
dv/sha256_byte_stream_hasher_unit_tb.sv
